### design/zpip_pkg.sv
package zpip_pkg;

   // command codes of the request channel
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // answer codes of the response channel
   localparam logic [1:0] STATUS_OUTSIDE = 2'd0;
   localparam logic [1:0] STATUS_INSIDE  = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

endpackage

### design/zpip_ram.sv
module zpip_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/zone_point_in_polygon.sv
// Geofence: polygon zones held in a vertex memory, tested by even-odd ray casting.
// Request channel (req_valid / req_stall): req_cmd load writes one vertex of a
// zone at req_vertex_index; req_vertex_last also sets the zone's vertex count to
// that index plus one. req_cmd query tests point (req_coord_x, req_coord_y),
// signed Q16.16, against req_zone. Loads give no response.
// Response channel (rsp_valid / rsp_stall): rsp_status outside, inside, or
// unknown zone (zone out of range or never loaded).
// After a load the sequencer stays idle and takes the next transaction at once.
// A query scans the zone's edges in turn (an unknown zone skips the scan);
// req_stall stays high meanwhile. The scan pace is set by the single shared
// multiplier: each edge has a setup step and then a product step for each of
// its two cross products, while the vertex memory streams one vertex per edge.
// The response sits in an output register: while rsp_stall is high it holds,
// and loads are still taken; a following query finishes its scan and then waits
// for the register to free up.
// Reset clears all vertex counts (every zone reads as unknown) and the
// response; vertex memory contents are not cleared.
module zone_point_in_polygon #(
   parameter int ZONES        = 4,
   parameter int MAX_VERTICES = 16,
   parameter int COORD_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [1:0]  req_zone,
   input  logic [3:0]  req_vertex_index,
   input  logic        req_vertex_last,
   input  logic [31:0] req_coord_x,
   input  logic [31:0] req_coord_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status
);

   localparam int DEPTH  = ZONES * MAX_VERTICES;
   localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int ZI_W   = ZONES > 1 ? $clog2(ZONES) : 1;
   localparam int IDX_W  = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int DW     = COORD_BITS + 1;
   localparam int PW     = 2 * DW;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PRIME = 7'b0000010,
      ST_EDGE  = 7'b0000100,
      ST_MUL_A = 7'b0001000,
      ST_MUL_B = 7'b0010000,
      ST_LAST  = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  cnt_ff [ZONES];
   logic [CNT_W-1:0]  cnt_in [ZONES];
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  last_idx_ff, last_idx_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic signed [COORD_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [COORD_BITS-1:0] xj_ff, xj_in, yj_ff, yj_in;
   logic signed [DW-1:0] dx_ff, dx_in, dyabs_ff, dyabs_in;
   logic signed [DW-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic cross_ff, cross_in;
   logic signed [PW-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic inside_ff, inside_in;
   logic [1:0] status_pend_ff, status_pend_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   // request decode
   logic [ZI_W-1:0]   zi;
   logic              zone_ok, vidx_ok, accept, rsp_free;
   logic [CNT_W-1:0]  zone_cnt;
   logic [ADDR_W-1:0] req_base;
   logic signed [COORD_BITS-1:0] req_x, req_y;

   // memory ports
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [2*COORD_BITS-1:0] ram_rd_data;
   logic signed [COORD_BITS-1:0] xi, yi;

   // edge setup and shared multiplier
   logic signed [DW-1:0] dy, ey_raw;
   logic signed [DW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   logic flip;

   assign zi       = ZI_W'(req_zone);
   assign zone_ok  = {30'd0, req_zone} < 32'(ZONES);
   assign vidx_ok  = {28'd0, req_vertex_index} < 32'(MAX_VERTICES);
   assign zone_cnt = zone_ok ? cnt_ff[zi] : '0;
   assign req_base = ADDR_W'(zi * MAX_VERTICES);
   assign req_x    = req_coord_x[COORD_BITS-1:0];
   assign req_y    = req_coord_y[COORD_BITS-1:0];
   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = (state_ff != ST_IDLE);

   assign xi = ram_rd_data[COORD_BITS-1:0];
   assign yi = ram_rd_data[2*COORD_BITS-1:COORD_BITS];

   // edge terms, oriented so the y span is non-negative
   assign dy     = DW'(yj_ff) - DW'(yi);
   assign ey_raw = DW'(y_ff) - DW'(yi);

   // one multiplier shared by both cross products of an edge
   assign mul_a = (state_ff == ST_MUL_A) ? dx_ff : ex_ff;
   assign mul_b = (state_ff == ST_MUL_A) ? dyabs_ff : ey_ff;
   assign mul_p = PW'(mul_a) * PW'(mul_b);

   // a crossing of the previous edge right of the point toggles the parity
   assign flip = cross_ff && (prod_a_ff < prod_b_ff);

   // vertex write on load, streaming read on query
   assign ram_wr_en   = accept && (req_cmd == zpip_pkg::CMD_LOAD) && zone_ok && vidx_ok;
   assign ram_wr_addr = req_base + ADDR_W'(req_vertex_index);

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = base_ff;
      case (state_ff)
         ST_IDLE: begin
            ram_rd_en   = accept && (req_cmd == zpip_pkg::CMD_QUERY);
            ram_rd_addr = req_base + ADDR_W'(IDX_W'(zone_cnt - CNT_W'(1)));
         end
         ST_PRIME: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = base_ff;
         end
         ST_MUL_B: begin
            ram_rd_en   = (idx_ff != last_idx_ff);
            ram_rd_addr = base_ff + ADDR_W'(idx_ff) + ADDR_W'(1);
         end
         default: begin
            ram_rd_en   = 1'b0;
            ram_rd_addr = base_ff;
         end
      endcase
   end

   zpip_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (DEPTH)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_y, req_x}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      last_idx_in    = last_idx_ff;
      base_in        = base_ff;
      x_in           = x_ff;
      y_in           = y_ff;
      xj_in          = xj_ff;
      yj_in          = yj_ff;
      dx_in          = dx_ff;
      dyabs_in       = dyabs_ff;
      ex_in          = ex_ff;
      ey_in          = ey_ff;
      cross_in       = cross_ff;
      prod_a_in      = prod_a_ff;
      prod_b_in      = prod_b_ff;
      inside_in      = inside_ff;
      status_pend_in = status_pend_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == zpip_pkg::CMD_LOAD) begin
                  if (zone_ok && vidx_ok && req_vertex_last) begin
                     cnt_in[zi] = CNT_W'({1'b0, req_vertex_index} + 5'd1);
                  end
               end else if (zone_cnt == '0) begin
                  status_pend_in = zpip_pkg::STATUS_UNKNOWN;
                  state_in       = ST_DONE;
               end else begin
                  x_in        = req_x;
                  y_in        = req_y;
                  base_in     = req_base;
                  last_idx_in = IDX_W'(zone_cnt - CNT_W'(1));
                  state_in    = ST_PRIME;
               end
            end
         end
         // last vertex arrives as the first edge's far end
         ST_PRIME: begin
            xj_in     = xi;
            yj_in     = yi;
            idx_in    = '0;
            cross_in  = 1'b0;
            inside_in = 1'b0;
            state_in  = ST_EDGE;
         end
         // close out the previous edge, set up operands of this one
         ST_EDGE: begin
            inside_in = inside_ff ^ flip;
            cross_in  = (yi > y_ff) != (yj_ff > y_ff);
            dx_in     = DW'(x_ff) - DW'(xi);
            ex_in     = DW'(xj_ff) - DW'(xi);
            dyabs_in  = dy[DW-1] ? -dy : dy;
            ey_in     = dy[DW-1] ? -ey_raw : ey_raw;
            xj_in     = xi;
            yj_in     = yi;
            state_in  = ST_MUL_A;
         end
         ST_MUL_A: begin
            prod_a_in = mul_p;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            prod_b_in = mul_p;
            if (idx_ff == last_idx_ff) begin
               state_in = ST_LAST;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_EDGE;
            end
         end
         ST_LAST: begin
            status_pend_in = (inside_ff ^ flip) ? zpip_pkg::STATUS_INSIDE
                                                : zpip_pkg::STATUS_OUTSIDE;
            state_in       = ST_DONE;
         end
         // hand off to the response register once it is free
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_pend_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int z = 0; z < ZONES; z++) begin
            cnt_ff[z] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      last_idx_ff    <= last_idx_in;
      base_ff        <= base_in;
      x_ff           <= x_in;
      y_ff           <= y_in;
      xj_ff          <= xj_in;
      yj_ff          <= yj_in;
      dx_ff          <= dx_in;
      dyabs_ff       <= dyabs_in;
      ex_ff          <= ex_in;
      ey_ff          <= ey_in;
      cross_ff       <= cross_in;
      prod_a_ff      <= prod_a_in;
      prod_b_ff      <= prod_b_in;
      inside_ff      <= inside_in;
      status_pend_ff <= status_pend_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

### design/zpip_checker.sv
module zpip_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_cmd,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status
);

   // a stalled response holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("stalled response changed");

   // only the three defined answers appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == zpip_pkg::STATUS_OUTSIDE ||
                     rsp_status == zpip_pkg::STATUS_INSIDE ||
                     rsp_status == zpip_pkg::STATUS_UNKNOWN))
      else $error("undefined response status");

   // a query transaction keeps the request side busy while it runs
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == zpip_pkg::CMD_QUERY |=> req_stall)
      else $error("query accepted without going busy");

   // a load never produces a response
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == zpip_pkg::CMD_LOAD && !rsp_valid
      |=> !rsp_valid)
      else $error("load produced a response");

   // no response right out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind zone_point_in_polygon zpip_checker u_zpip_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_cmd    (req_cmd),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_status (rsp_status)
);

### tb/sv/tb_zone_point_in_polygon.sv
`timescale 1ns / 1ps

module tb_zone_point_in_polygon;

   localparam int TOTAL_REQUESTS = 1250;
   localparam logic [31:0] COORD_MAX = 32'h7fff_ffff;
   localparam logic [31:0] COORD_MIN = 32'h8000_0000;

   typedef struct {
      logic        cmd;
      logic [1:0]  zone;
      logic [3:0]  vidx;
      logic        last;
      logic [31:0] x;
      logic [31:0] y;
      bit          hold;
   } zone_req_type;

   typedef enum int {COORD_BOX, COORD_FULL, COORD_EDGE} coord_kind_type;
   typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY} stall_kind_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_cmd          = zpip_pkg::CMD_LOAD;
   logic [1:0]  req_zone         = 2'd0;
   logic [3:0]  req_vertex_index = 4'd0;
   logic        req_vertex_last  = 1'b0;
   logic [31:0] req_coord_x      = 32'd0;
   logic [31:0] req_coord_y      = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [1:0]  rsp_status;

   // pending requests and expected answers
   zone_req_type request_q [$];
   logic [1:0]   expected_status_q [$];
   int           request_total;
   int           requests_taken = 0;
   bit           req_taken = 1'b0;
   bit           hold_next = 1'b0;

   // generator view of the zone table, kept so that no query reads an unwritten vertex
   int unsigned gen_count [4];
   bit          gen_written [4][16];

   // predicted zone table
   logic [31:0] vtx_x [4][16];
   logic [31:0] vtx_y [4][16];
   logic [4:0]  zone_count [4];

   int err_count     = 0;
   int load_count    = 0;
   int inside_count  = 0;
   int outside_count = 0;
   int unknown_count = 0;

   zone_point_in_polygon DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_zone         (req_zone),
      .req_vertex_index (req_vertex_index),
      .req_vertex_last  (req_vertex_last),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // even-odd ray cast with exact 66-bit cross products
   function automatic logic [1:0] locate_point(input logic [1:0] zone, input logic [31:0] x_in,
                                               input logic [31:0] y_in);
      logic signed [65:0] px, py, xi, yi, xj, yj, dy, ey;
      int unsigned n, i, j;
      bit odd;
      n = zone_count[zone];
      odd = 1'b0;
      if (n == 0) return zpip_pkg::STATUS_UNKNOWN;
      px = $signed(x_in);
      py = $signed(y_in);
      for (i = 0; i < n; i++) begin
         j = (i == 0) ? n - 1 : i - 1;
         xi = $signed(vtx_x[zone][i]);
         yi = $signed(vtx_y[zone][i]);
         xj = $signed(vtx_x[zone][j]);
         yj = $signed(vtx_y[zone][j]);
         if ((yi > py) != (yj > py)) begin
            dy = yj - yi;
            ey = py - yi;
            if (dy < 0) begin
               dy = -dy;
               ey = -ey;
            end
            if ((px - xi) * dy < (xj - xi) * ey) odd = !odd;
         end
      end
      return odd ? zpip_pkg::STATUS_INSIDE : zpip_pkg::STATUS_OUTSIDE;
   endfunction

   // coordinate in a box of random size, fully random, or random mixed with range limits and values around zero
   function automatic logic [31:0] pick_coord(input coord_kind_type kind,
                                              input int unsigned span_log);
      longint span;
      longint v;
      span = longint'(1) << span_log;
      case (kind)
         COORD_BOX: begin
            v = longint'($urandom_range(0, 32'(2 * span))) - span;
            return v[31:0];
         end
         COORD_FULL: return $urandom;
         default: begin
            if ($urandom_range(0, 1) == 1) return $urandom;
            case ($urandom_range(0, 5))
               0: return COORD_MIN;
               1: return COORD_MIN + 32'd1;
               2: return 32'hffff_ffff;
               3: return 32'd0;
               4: return 32'd1;
               default: return COORD_MAX;
            endcase
         end
      endcase
   endfunction

   function automatic bit zone_readable(input int z);
      int unsigned k;
      for (k = 0; k < gen_count[z]; k++)
         if (!gen_written[z][k]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic push_item(input logic cmd, input logic [1:0] zone, input logic [3:0] vidx,
                            input logic last, input logic [31:0] x, input logic [31:0] y);
      zone_req_type it;
      it.cmd  = cmd;
      it.zone = zone;
      it.vidx = vidx;
      it.last = last;
      it.x    = x;
      it.y    = y;
      it.hold = hold_next;
      hold_next = 1'b0;
      if (cmd == zpip_pkg::CMD_LOAD) begin
         gen_written[zone][vidx] = 1'b1;
         if (last) gen_count[zone] = vidx + 1;
      end
      request_q.insert(request_q.size(), it);
   endtask

   // query fields that a query does not use still get random values
   task automatic push_query(input logic [1:0] zone, input logic [31:0] x, input logic [31:0] y);
      push_item(zpip_pkg::CMD_QUERY, zone, 4'($urandom_range(0, 15)),
                1'($urandom_range(0, 1)), x, y);
   endtask

   // stimulus, then wait for the last answer and report
   initial begin
      int pick, n, k, z, span_log;
      coord_kind_type kind;
      for (z = 0; z < 4; z++) begin
         gen_count[z] = 0;
         for (k = 0; k < 16; k++) gen_written[z][k] = 1'b0;
      end

      // zone never loaded
      push_query(2'd0, COORD_MIN, COORD_MAX);
      // single vertex zone: no edge can cross
      push_item(zpip_pkg::CMD_LOAD, 2'd1, 4'd0, 1'b1, COORD_MAX, COORD_MIN);
      push_query(2'd1, COORD_MIN, COORD_MIN);
      // two vertex zone spanning the full range
      push_item(zpip_pkg::CMD_LOAD, 2'd2, 4'd0, 1'b0, COORD_MIN, COORD_MIN);
      push_item(zpip_pkg::CMD_LOAD, 2'd2, 4'd1, 1'b1, COORD_MAX, COORD_MAX);
      push_query(2'd2, COORD_MIN, 32'd0);
      // square at the extreme corners, widest differences and products
      push_item(zpip_pkg::CMD_LOAD, 2'd0, 4'd0, 1'b0, COORD_MIN, COORD_MIN);
      push_item(zpip_pkg::CMD_LOAD, 2'd0, 4'd1, 1'b0, COORD_MAX, COORD_MIN);
      push_item(zpip_pkg::CMD_LOAD, 2'd0, 4'd2, 1'b0, COORD_MAX, COORD_MAX);
      push_item(zpip_pkg::CMD_LOAD, 2'd0, 4'd3, 1'b1, COORD_MIN, COORD_MAX);
      push_query(2'd0, 32'd0, 32'd0);
      push_query(2'd0, COORD_MIN, 32'h0001_0000);
      push_query(2'd0, COORD_MAX, COORD_MAX);
      // count set by a high last vertex before the lower ones are written
      push_item(zpip_pkg::CMD_LOAD, 2'd3, 4'd5, 1'b1, 32'h0004_0000, 32'h0000_0000);
      for (k = 0; k < 5; k++)
         push_item(zpip_pkg::CMD_LOAD, 2'd3, 4'(k), 1'b0, $urandom_range(0, 32'h3_ffff),
                   $urandom_range(0, 32'h3_ffff) - 32'h2_0000);
      hold_next = 1'b1;
      push_query(2'd3, 32'h0001_8000, 32'h0000_8000);

      // random part: whole polygons followed by queries, single queries on readable zones, and noise loads
      while (request_q.size() < TOTAL_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 149) == 0) hold_next = 1'b1;
         if (pick < 60) begin
            z = $urandom_range(0, 3);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
            kind = ($urandom_range(0, 9) < 7) ? COORD_BOX
                                              : coord_kind_type'($urandom_range(1, 2));
            span_log = $urandom_range(2, 30);
            for (k = 0; k < n; k++)
               push_item(zpip_pkg::CMD_LOAD, 2'(z), 4'(k), k == n - 1,
                         pick_coord(kind, span_log), pick_coord(kind, span_log));
            repeat ($urandom_range(1, 6))
               push_query(2'(z), pick_coord(kind, span_log), pick_coord(kind, span_log));
         end else if (pick < 85 && zone_readable(pick % 4)) begin
            span_log = $urandom_range(2, 30);
            kind = coord_kind_type'($urandom_range(0, 2));
            push_query(2'(pick % 4), pick_coord(kind, span_log), pick_coord(kind, span_log));
         end else begin
            push_item(zpip_pkg::CMD_LOAD, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                      $urandom_range(0, 3) == 0, $urandom, $urandom);
         end
      end
      request_total = request_q.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (requests_taken < request_total || expected_status_q.size() != 0)
         @(negedge clock);
      repeat (80) @(negedge clock);

      $display("run covered %0d vertex loads and %0d point queries",
               load_count, inside_count + outside_count + unknown_count);
      $display("answers: %0d inside, %0d outside, %0d unknown zone",
               inside_count, outside_count, unknown_count);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // request driver: bursts of transactions separated by random gaps
   zone_req_type cur;
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_q.size() == 0 ||
                      (request_q[0].hold && expected_status_q.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            cur = request_q.pop_front();
            req_cmd          <= cur.cmd;
            req_zone         <= cur.zone;
            req_vertex_index <= cur.vidx;
            req_vertex_last  <= cur.last;
            req_coord_x      <= cur.x;
            req_coord_y      <= cur.y;
            req_valid        <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
   end

   // response stall: pattern switches among free flow, half and heavy backpressure
   stall_kind_type stall_kind = STALL_NONE;
   int stall_left = 0;

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_kind = stall_kind_type'($urandom_range(0, 2));
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_kind)
         STALL_NONE: rsp_stall <= 1'b0;
         STALL_HALF: rsp_stall <= ($urandom_range(0, 1) == 1);
         default:    rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // monitor: check answers, then predict from each accepted transaction
   logic [1:0] want;

   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
         for (int z = 0; z < 4; z++) zone_count[z] = 5'd0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_status_q.size() == 0) begin
               $error("unexpected response transaction, status %0d", rsp_status);
               err_count++;
            end else begin
               want = expected_status_q.pop_front();
               if (rsp_status !== want) begin
                  $error("status mismatch: expected %0d, actual %0d", want, rsp_status);
                  err_count++;
               end
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            requests_taken++;
            if (req_cmd == zpip_pkg::CMD_LOAD) begin
               vtx_x[req_zone][req_vertex_index] = req_coord_x;
               vtx_y[req_zone][req_vertex_index] = req_coord_y;
               if (req_vertex_last) zone_count[req_zone] = req_vertex_index + 5'd1;
               load_count++;
            end else begin
               want = locate_point(req_zone, req_coord_x, req_coord_y);
               expected_status_q.insert(expected_status_q.size(), want);
               case (want)
                  zpip_pkg::STATUS_INSIDE:  inside_count++;
                  zpip_pkg::STATUS_OUTSIDE: outside_count++;
                  default:                  unknown_count++;
               endcase
            end
         end
      end
   end

endmodule

### zone_point_in_polygon.f
design/zpip_pkg.sv
design/zpip_ram.sv
design/zone_point_in_polygon.sv
design/zpip_checker.sv
tb/sv/tb_zone_point_in_polygon.sv
